// File: hdl/asp_pkg.sv
package asp_pkg;

  localparam int unsigned SITES    = 64;
  localparam int unsigned SITE_W   = 6;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned INTVL_W  = 16;

  // site numbers at or above this limit are out of the table
  localparam logic [SITE_W:0]    SITE_LIMIT       = (SITE_W + 1)'(SITES);
  localparam logic [INTVL_W-1:0] INTVL_RESET      = INTVL_W'(100);
  localparam logic [CNT_W-1:0]   CNT_MAX          = {CNT_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0]  phase;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] prev_addr;
    logic [ADDR_W-1:0] stride;
    logic              mono;
    logic              cons;
  } site_entry_t;

  // contents of an entry that was never written
  localparam site_entry_t ENTRY_RESET = '{
    phase:     '0,
    count:     '0,
    prev_addr: '0,
    stride:    '0,
    mono:      1'b1,
    cons:      1'b1
  };

endpackage

// File: hdl/asp_ram.sv
module asp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/access_stride_profiler.sv
// Per-site stride profiler. Each input word is one memory access (site index
// and 64-bit byte address); each access gives exactly one result word, in
// order. Per site, one access out of every interval-register value is sampled
// (an interval of 0 behaves as 1; lowering the interval below a site's phase
// makes that site's next access sampled). A sampled access bumps a saturating
// 16-bit count, keeps the address, clears the monotonic flag when the address
// does not rise, takes the first nonzero modulo-2^64 delta as the stride and
// clears the constant-stride flag on any later delta that differs. Accesses
// without context change nothing and report the site's current state. The
// block takes one access per clock when the result side does not stall:
// the table lives in a 64-entry RAM with a registered read, the access waits
// in an input register for the read data, is updated there and written
// back, and its result lands in an output register. Back-to-back accesses
// to the same site see the previous update through a one-entry bypass. All
// entries read as cleared right after reset through per-entry valid flops,
// so no clearing pass is needed. Write the interval register only while
// idle.
module access_stride_profiler
  import asp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [INTVL_W-1:0] cfg_wdata_i,
  // access words in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               has_context_i,
  input  logic [SITE_W-1:0]  site_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic               is_store_i,
  // result words out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               sampled_o,
  output logic               monotonic_o,
  output logic               constant_stride_o,
  output logic               stride_valid_o,
  output logic [ADDR_W-1:0]  stride_value_o,
  output logic [CNT_W-1:0]   sample_total_o
);

  localparam int unsigned EW = $bits(site_entry_t);

  // sample interval register
  logic [INTVL_W-1:0] intvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intvl_q <= INTVL_RESET;
    end else if (cfg_we_i) begin
      intvl_q <= cfg_wdata_i;
    end
  end

  // handshake control
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic in_acc;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // input register
  logic              ctx_q;
  logic [SITE_W-1:0] site_q;
  logic [ADDR_W-1:0] addr_q;
  logic              store_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctx_q   <= has_context_i;
      site_q  <= site_i;
      addr_q  <= address_i;
      // kind of access is carried along but has no effect on profiling
      store_q <= is_store_i;
    end
  end

  // table ram; hold the read address while the input register is held so
  // the read data keeps tracking the addressed entry
  logic              wr_en;
  site_entry_t       wr_entry;
  logic [SITE_W-1:0] rd_site;
  logic [EW-1:0]     rd_data;

  assign rd_site = in_stall_o ? site_q : site_i;

  asp_ram #(
    .WIDTH (EW),
    .DEPTH (SITES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (site_q),
    .wdata_i (wr_entry),
    .raddr_i (rd_site),
    .rdata_o (rd_data)
  );

  // written flags per entry; unwritten entries read as the cleared entry
  logic [SITES-1:0] written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_en) begin
      written_q[site_q] <= 1'b1;
    end
  end

  // bypass of the write done in the previous cycle (ram reads old data)
  logic              byp_valid_q;
  logic [SITE_W-1:0] byp_site_q;
  site_entry_t       byp_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else begin
      byp_valid_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      byp_site_q  <= site_q;
      byp_entry_q <= wr_entry;
    end
  end

  site_entry_t cur;

  always_comb begin
    if (byp_valid_q && (byp_site_q == site_q)) begin
      cur = byp_entry_q;
    end else if (written_q[site_q]) begin
      cur = site_entry_t'(rd_data);
    end else begin
      cur = ENTRY_RESET;
    end
  end

  // update of the addressed entry
  logic              in_range;
  logic [INTVL_W:0]  phase_nxt;
  logic              take;
  logic [ADDR_W-1:0] delta;
  site_entry_t       upd;

  assign in_range  = ({1'b0, site_q} < SITE_LIMIT);
  assign phase_nxt = {1'b0, cur.phase} + (INTVL_W + 1)'(1);
  assign take      = ctx_q && in_range && (phase_nxt >= {1'b0, intvl_q});
  assign delta     = addr_q - cur.prev_addr;

  always_comb begin
    upd = cur;
    if (take) begin
      upd.phase = '0;
      if (cur.count == '0) begin
        // first sample only records the address
        upd.prev_addr = addr_q;
        upd.stride    = '0;
      end else begin
        if (addr_q <= cur.prev_addr) begin
          upd.mono = 1'b0;
        end
        if (cur.stride == '0) begin
          upd.stride = delta;
        end else if (delta != cur.stride) begin
          upd.cons = 1'b0;
        end
        upd.prev_addr = addr_q;
      end
      if (cur.count != CNT_MAX) begin
        upd.count = cur.count + CNT_W'(1);
      end
    end else begin
      upd.phase = phase_nxt[INTVL_W-1:0];
    end
  end

  assign wr_en    = s1_adv && ctx_q && in_range;
  assign wr_entry = upd;

  // result register
  logic              res_sampled_q;
  logic              res_mono_q;
  logic              res_cons_q;
  logic              res_svalid_q;
  logic [ADDR_W-1:0] res_stride_q;
  logic [CNT_W-1:0]  res_count_q;
  site_entry_t       rep;

  // out-of-range sites report all zeros
  assign rep = in_range ? upd : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_sampled_q <= take;
      res_mono_q    <= rep.mono;
      res_cons_q    <= rep.cons;
      res_svalid_q  <= rep.cons && (rep.stride != '0);
      res_stride_q  <= rep.stride;
      res_count_q   <= rep.count;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sampled_o         = res_sampled_q;
  assign monotonic_o       = res_mono_q;
  assign constant_stride_o = res_cons_q;
  assign stride_valid_o    = res_svalid_q;
  assign stride_value_o    = res_stride_q;
  assign sample_total_o    = res_count_q;

  logic unused_store;
  assign unused_store = store_q;

endmodule

// File: verif/tb_top.sv
module tb_top
  import asp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // no accepted word on either side for this many cycles ends the run
  localparam int unsigned HANG_LIMIT = 5000;

  // one result word as the block reports it
  typedef struct packed {
    logic              sampled;
    logic              monotonic;
    logic              constant_stride;
    logic              stride_valid;
    logic [ADDR_W-1:0] stride_value;
    logic [CNT_W-1:0]  sample_total;
  } stride_report_t;

  // per-site stride table kept in step with the block, plus the queue of
  // reports still owed by it
  class stride_scoreboard;
    logic [INTVL_W-1:0] interval;
    site_entry_t        site_table [SITES];
    stride_report_t     owed_q [$];
    int unsigned        mismatches;
    int unsigned        reports_seen;
    int unsigned        samples_seen;

    function new();
      interval = INTVL_RESET;
      foreach (site_table[i]) site_table[i] = ENTRY_RESET;
      mismatches   = 0;
      reports_seen = 0;
      samples_seen = 0;
    endfunction

    function void set_interval(logic [INTVL_W-1:0] value);
      interval = value;
    endfunction

    // an access word was accepted: update the site and queue its report
    function void note_access(logic ctx, logic [SITE_W-1:0] site, logic [ADDR_W-1:0] addr);
      site_entry_t       e;
      logic [CNT_W:0]    next_phase;
      logic [ADDR_W-1:0] delta;
      stride_report_t    r;
      e = site_table[site];
      r.sampled = 1'b0;
      if (ctx) begin
        next_phase = {1'b0, e.phase} + (CNT_W + 1)'(1);
        // an interval of zero compares like one, so every access is sampled
        if (next_phase < {1'b0, interval}) begin
          e.phase = next_phase[CNT_W-1:0];
        end else begin
          e.phase   = '0;
          r.sampled = 1'b1;
          if (e.count == '0) begin
            e.prev_addr = addr;
            e.stride    = '0;
          end else begin
            delta = addr - e.prev_addr;
            if (addr <= e.prev_addr) e.mono = 1'b0;
            if (e.stride == '0) e.stride = delta;
            else if (delta != e.stride) e.cons = 1'b0;
            e.prev_addr = addr;
          end
          if (e.count != CNT_MAX) e.count = e.count + CNT_W'(1);
        end
        site_table[site] = e;
      end
      r.monotonic       = e.mono;
      r.constant_stride = e.cons;
      r.stride_valid    = e.cons && (e.stride != '0);
      r.stride_value    = e.stride;
      r.sample_total    = e.count;
      owed_q.push_back(r);
    endfunction

    // a result word was accepted: compare it with the oldest owed report
    function void check_report(stride_report_t got);
      stride_report_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word with no access pending: stride=%h total=%0d",
                   got.stride_value, got.sample_total);
        return;
      end
      want = owed_q.pop_front();
      reports_seen++;
      if (want.sampled) samples_seen++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected s=%b m=%b c=%b v=%b stride=%h total=%0d,%s",
                   reports_seen, want.sampled, want.monotonic, want.constant_stride,
                   want.stride_valid, want.stride_value, want.sample_total,
                   $sformatf(" got s=%b m=%b c=%b v=%b stride=%h total=%0d",
                             got.sampled, got.monotonic, got.constant_stride,
                             got.stride_valid, got.stride_value, got.sample_total));
      end
    endfunction
  endclass

  // block ports; every input is known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [INTVL_W-1:0] cfg_wdata_i   = '0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic               has_context_i = 1'b0;
  logic [SITE_W-1:0]  site_i        = '0;
  logic [ADDR_W-1:0]  address_i     = '0;
  logic               is_store_i    = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic               sampled_o;
  logic               monotonic_o;
  logic               constant_stride_o;
  logic               stride_valid_o;
  logic [ADDR_W-1:0]  stride_value_o;
  logic [CNT_W-1:0]   sample_total_o;

  // idle odds in percent for each side, changed between phases
  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 47;
  int unsigned quiet_cycles  = 0;
  int unsigned words_sent    = 0;

  // per-site address streams for the random part: next address and step
  logic [ADDR_W-1:0] stream_next [SITES];
  logic [ADDR_W-1:0] stream_step [SITES];

  stride_scoreboard sb;

  access_stride_profiler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .has_context_i    (has_context_i),
    .site_i           (site_i),
    .address_i        (address_i),
    .is_store_i       (is_store_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sampled_o        (sampled_o),
    .monotonic_o      (monotonic_o),
    .constant_stride_o(constant_stride_o),
    .stride_valid_o   (stride_valid_o),
    .stride_value_o   (stride_value_o),
    .sample_total_o   (sample_total_o)
  );

  always #1 clk_i = ~clk_i;

  // receiver side: random stall at the current odds
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // result monitor and hang watchdog; values read here are the ones
  // sampled at this edge, since every driver uses nonblocking updates
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_report('{sampled_o, monotonic_o, constant_stride_o, stride_valid_o,
                        stride_value_o, sample_total_o});
    if ((in_valid_i && !in_stall_o) || (rst_ni && out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == HANG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // a stride for a fresh stream: small up or down steps, or anything at all
  function automatic logic [ADDR_W-1:0] pick_step();
    case ($urandom_range(5))
      0:       return 64'd8;
      1:       return 64'd64;
      2:       return 64'hFFFF_FFFF_FFFF_FFF0;
      3:       return 64'($urandom_range(4096, 1));
      4:       return {$urandom, $urandom};
      default: return 64'd4;
    endcase
  endfunction

  // present one access word, idling first at the sender odds, and hold it
  // until accepted; valid stays high on return so back-to-back words flow
  task automatic send_access(input logic ctx, input logic [SITE_W-1:0] site,
                             input logic [ADDR_W-1:0] addr, input logic store);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    has_context_i <= ctx;
    site_i        <= site;
    address_i     <= addr;
    is_store_i    <= store;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(ctx, site, addr);
    words_sent++;
  endtask

  // sender holds off until every owed report has come back, then waits out
  // an idle margin
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // the interval register is only written with the block idle
  task automatic write_interval(input logic [INTVL_W-1:0] value);
    drain_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_interval(value);
    cfg_we_i <= 1'b0;
  endtask

  // mostly strided streams on a few hot sites, with jumps, repeated
  // addresses, stride changes and context-less noise mixed in
  task automatic run_streams(input int unsigned count);
    int unsigned       hot_base;
    int unsigned       pick;
    logic [SITE_W-1:0] s;
    logic [ADDR_W-1:0] a;
    logic              ctx;
    hot_base = $urandom_range(SITES - 4);
    repeat (count) begin
      if ($urandom_range(99) < 70) s = SITE_W'(hot_base + $urandom_range(3));
      else s = SITE_W'($urandom);
      pick = $urandom_range(99);
      ctx  = 1'b1;
      if (pick < 8) begin
        ctx = 1'b0;
        a   = {$urandom, $urandom};
      end else if (pick < 16) begin
        // jump somewhere new and carry on from there
        a = {$urandom, $urandom};
        stream_next[s] = a + stream_step[s];
      end else if (pick < 22) begin
        // same address again, a zero delta
        a = stream_next[s] - stream_step[s];
      end else begin
        if (pick < 26) stream_step[s] = pick_step();
        a = stream_next[s];
        stream_next[s] = a + stream_step[s];
      end
      send_access(ctx, s, a, 1'($urandom));
    end
  endtask

  initial begin
    logic [INTVL_W-1:0] intvl;
    int unsigned        sel;
    sb = new();
    foreach (stream_next[i]) begin
      stream_next[i] = {$urandom, $urandom};
      stream_step[i] = pick_step();
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset interval of 100: phases only build up, context-less word ignored
    send_access(1'b1, 6'd63, 64'h0, 1'b1);
    send_access(1'b1, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_access(1'b0, 6'd63, 64'h1234_5678_9ABC_DEF0, 1'b1);
    send_access(1'b1, 6'd7, 64'h1000, 1'b0);

    // interval zero acts as one and sits below the built-up phases
    write_interval('0);
    send_access(1'b1, 6'd63, 64'd100, 1'b0);  // first sample keeps address
    send_access(1'b1, 6'd63, 64'd100, 1'b0);  // zero delta, stride stays clear
    send_access(1'b1, 6'd63, 64'd164, 1'b1);  // first nonzero delta sets stride
    send_access(1'b1, 6'd63, 64'd228, 1'b0);  // same stride
    send_access(1'b1, 6'd63, 64'd300, 1'b0);  // stride broken
    send_access(1'b0, 6'd63, 64'd0, 1'b0);    // reports state, no change
    send_access(1'b1, 6'd0, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1);
    send_access(1'b1, 6'd0, 64'h0, 1'b0);     // delta wraps mod 2^64, not rising
    send_access(1'b1, 6'd0, 64'h8, 1'b1);

    // largest interval: nothing gets sampled
    write_interval('1);
    send_access(1'b1, 6'd1, 64'h40, 1'b0);
    send_access(1'b1, 6'd0, 64'h10, 1'b1);
    send_access(1'b1, 6'd1, 64'h80, 1'b0);

    // every third access of a site sampled
    write_interval(INTVL_W'(3));
    for (int i = 1; i <= 6; i++) send_access(1'b1, 6'd2, 64'(i * 64), 1'(i));

    // random streams under three idle mixes, a new interval per chunk
    for (int mix = 0; mix < 3; mix++) begin
      send_idle_pct = (mix == 0) ? 30 : (mix == 1) ? 47 : 0;
      recv_idle_pct = (mix == 0) ? 47 : (mix == 1) ? 30 : 0;
      repeat (4) begin
        sel = $urandom_range(9);
        if (sel < 3) intvl = INTVL_W'(1);
        else if (sel < 4) intvl = '0;
        else if (sel < 9) intvl = INTVL_W'($urandom_range(8, 2));
        else intvl = INTVL_W'($urandom_range(300, 9));
        write_interval(intvl);
        run_streams(120);
      end
    end
    drain_reports();

    $display("checked %0d access words, %0d of them sampled,", sb.reports_seen,
             sb.samples_seen);
    $display("across three idle mixes and intervals from 0 to 65535");
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
